>>> rtl/utf8d_pkg.sv
// Package for the UTF-8 stream decoder: widths, the replacement code point
// and the record that passes from the byte classifier to the beat emitter.
// No dependencies.
`default_nettype none

package utf8d_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CP_W   = 21;

    localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h00FFFD;

    // One classified byte: all beats but the last carry U+FFFD, the last
    // carries tail_cp. extra_cnt is the number of beats before the last.
    typedef struct packed {
        logic [1:0]      extra_cnt;
        logic [CP_W-1:0] tail_cp;
    } entry_t;

endpackage

`default_nettype wire

>>> rtl/utf8d_front.sv
// Front part of the UTF-8 stream decoder: accepts bytes, tracks the open
// sequence and turns each byte into at most one queue record.
// Depends on utf8d_pkg.
`default_nettype none

module utf8d_front (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       byte_fire,
    input  wire logic [utf8d_pkg::BYTE_W-1:0] byte_value,
    input  wire logic                       end_of_text,
    output logic                            push_valid,
    output utf8d_pkg::entry_t               push_entry
);

    logic [utf8d_pkg::CP_W-1:0] pv_reg, pv_next;
    logic [1:0]                 needed_reg, needed_next;
    logic [1:0]                 seen_reg, seen_next;
    logic [utf8d_pkg::CP_W-1:0] pv_shift;
    logic [utf8d_pkg::CP_W-1:0] tail;
    logic [2:0]                 n;

    assign pv_shift = {pv_reg[utf8d_pkg::CP_W-7:0], byte_value[5:0]};

    always_comb begin
        pv_next     = pv_reg;
        needed_next = needed_reg;
        seen_next   = seen_reg;
        n           = 3'd0;
        tail        = utf8d_pkg::REPLACEMENT_CP;
        if (needed_reg != 2'd0 && byte_value[7:6] == 2'b10) begin
            if (needed_reg == 2'd1) begin
                n           = 3'd1;
                tail        = pv_shift;
                pv_next     = '0;
                needed_next = 2'd0;
                seen_next   = 2'd0;
            end else begin
                pv_next     = pv_shift;
                needed_next = needed_reg - 2'd1;
                seen_next   = seen_reg + 2'd1;
            end
        end else begin
            if (needed_reg != 2'd0) begin
                n           = 3'd1 + {1'b0, seen_reg};
                pv_next     = '0;
                needed_next = 2'd0;
                seen_next   = 2'd0;
            end
            unique casez (byte_value)
                8'b0???????: begin
                    n    = n + 3'd1;
                    tail = {13'd0, byte_value};
                end
                8'b110?????: begin
                    pv_next     = {16'd0, byte_value[4:0]};
                    needed_next = 2'd1;
                    seen_next   = 2'd0;
                end
                8'b1110????: begin
                    pv_next     = {17'd0, byte_value[3:0]};
                    needed_next = 2'd2;
                    seen_next   = 2'd0;
                end
                8'b11110???: begin
                    pv_next     = {18'd0, byte_value[2:0]};
                    needed_next = 2'd3;
                    seen_next   = 2'd0;
                end
                default: begin
                    n    = n + 3'd1;
                    tail = utf8d_pkg::REPLACEMENT_CP;
                end
            endcase
        end
        if (end_of_text && needed_next != 2'd0) begin
            n           = n + 3'd1 + {1'b0, seen_next};
            tail        = utf8d_pkg::REPLACEMENT_CP;
            pv_next     = '0;
            needed_next = 2'd0;
            seen_next   = 2'd0;
        end
    end

    assign push_valid           = byte_fire && (n != 3'd0);
    assign push_entry.extra_cnt = 2'(n - 3'd1);
    assign push_entry.tail_cp   = tail;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pv_reg     <= '0;
            needed_reg <= 2'd0;
            seen_reg   <= 2'd0;
        end else if (byte_fire) begin
            pv_reg     <= pv_next;
            needed_reg <= needed_next;
            seen_reg   <= seen_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/utf8d_queue.sv
// Short queue of classified records between the front and back parts of
// the UTF-8 stream decoder. Depends on utf8d_pkg.
`default_nettype none

module utf8d_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  utf8d_pkg::entry_t      push_entry,
    output logic                   full,
    input  wire logic              pop,
    output logic                   not_empty,
    output utf8d_pkg::entry_t      head_entry
);

    localparam int unsigned PW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    utf8d_pkg::entry_t slots_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full       = (count_reg == CW'(DEPTH));
    assign not_empty  = (count_reg != '0);
    assign head_entry = slots_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/utf8d_back.sv
// Back part of the UTF-8 stream decoder: expands each queued record into
// its output beats from an output register. Depends on utf8d_pkg.
`default_nettype none

module utf8d_back (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        head_valid,
    input  utf8d_pkg::entry_t                head_entry,
    output logic                             pop,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [utf8d_pkg::CP_W-1:0]       out_cp,
    output logic                             out_last
);

    logic                       valid_reg, valid_next;
    logic [1:0]                 rem_reg, rem_next;
    logic [utf8d_pkg::CP_W-1:0] tail_reg, tail_next;
    logic                       load;

    assign load = !valid_reg || (out_ready && rem_reg == 2'd0);
    assign pop  = load && head_valid;

    always_comb begin
        valid_next = valid_reg;
        rem_next   = rem_reg;
        tail_next  = tail_reg;
        if (load) begin
            valid_next = head_valid;
            rem_next   = head_entry.extra_cnt;
            tail_next  = head_entry.tail_cp;
        end else if (out_ready) begin
            rem_next = rem_reg - 2'd1;
        end
    end

    assign out_valid = valid_reg;
    assign out_last  = (rem_reg == 2'd0);
    assign out_cp    = (rem_reg != 2'd0) ? utf8d_pkg::REPLACEMENT_CP : tail_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            rem_reg   <= 2'd0;
        end else begin
            valid_reg <= valid_next;
            rem_reg   <= rem_next;
        end
    end

    always_ff @(posedge aclk) begin
        tail_reg <= tail_next;
    end

endmodule

`default_nettype wire

>>> rtl/utf8_stream_decoder_top.sv
// Top level of the UTF-8 stream decoder: front classifier, record queue
// and beat emitter. Depends on utf8d_pkg, utf8d_front, utf8d_queue, utf8d_back.
`default_nettype none

// The decoder takes one UTF-8 byte per beat and can accept a byte every
// cycle while the queue has room. A byte that completes a character, or an
// ASCII byte, raises m_tvalid for its beat once its record has been
// written into the queue and then loaded into the output register, or
// later under output stalls; a byte that only opens or extends a sequence
// gives none. A malformed or cut-off sequence gives one U+FFFD beat per
// orphaned byte, up to four beats for one input byte, and the output side
// then emits them one after another. m_tlast marks the last beat caused by
// an input byte. The queue of QUEUE_DEPTH records absorbs those bursts and
// output stalls.
module utf8_stream_decoder_top #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] byte_value
    input  wire logic        s_tlast,   // end_of_text
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [20:0] code_point, [23:21] zero
    output logic             m_tlast    // last_of_run
);

    logic                       q_full;
    logic                       byte_fire;
    logic                       push_valid;
    utf8d_pkg::entry_t          push_entry;
    logic                       head_valid;
    utf8d_pkg::entry_t          head_entry;
    logic                       pop;
    logic [utf8d_pkg::CP_W-1:0] out_cp;

    assign s_tready  = !q_full;
    assign byte_fire = s_tvalid && !q_full;

    utf8d_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .byte_fire   (byte_fire),
        .byte_value  (s_tdata),
        .end_of_text (s_tlast),
        .push_valid  (push_valid),
        .push_entry  (push_entry)
    );

    utf8d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push_valid),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .not_empty  (head_valid),
        .head_entry (head_entry)
    );

    utf8d_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_cp     (out_cp),
        .out_last   (m_tlast)
    );

    assign m_tdata = {3'b000, out_cp};

endmodule

`default_nettype wire
